### rtl/tkg_pkg.sv
`default_nettype none
package tkg_pkg;

  localparam int KEY_MAX        = 32;
  localparam int OFFSET_BITS    = 32;
  localparam int MAX_RESULTS    = 32;
  localparam int KEY_LEN_OUT_W  = 6;
  localparam int BYTE_W         = 8;
  localparam int POS_W          = 32;

  localparam int KLEN_W = $clog2(KEY_MAX + 1);
  localparam int KIDX_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int RUN_W  = $clog2(MAX_RESULTS + 1);
  localparam int CNT_W  = $clog2(((KEY_MAX > MAX_RESULTS) ? KEY_MAX : MAX_RESULTS) + 1);

  localparam logic [BYTE_W-1:0] TAB_CHAR = 8'd9;
  localparam logic [BYTE_W-1:0] NL_CHAR  = 8'd10;
  localparam logic [BYTE_W-1:0] COL_MAX  = 8'd255;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]         group_start;
    logic [POS_W-1:0]         group_length;
    logic [KEY_LEN_OUT_W-1:0] key_length;
    logic [BYTE_W-1:0]        key_byte;
    logic                     key_truncated;
    logic                     last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_CMP_RD,
    ST_CMP_CHK,
    ST_RUN1,
    ST_RUN2,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT,
    ST_FINISH,
    ST_RESTART
  } ctrl_state_t;

  typedef struct packed {
    logic take_byte;
    logic take_line;
    logic clr_idx;
    logic inc_idx;
    logic load_run1;
    logic load_run2;
    logic out_load;
    logic line_reset;
    logic restart;
  } dp_cmd_t;

  typedef struct packed {
    logic line_close;
    logic first;
    logic eos;
    logic len_eq;
    logic llen_zero;
    logic byte_ne;
    logic idx_last;
    logic run_last;
  } dp_status_t;

  // results in one run: one per stored key byte, at least one, at most MAX_RESULTS
  function automatic logic [RUN_W-1:0] run_size(input logic [KLEN_W-1:0] len);
    logic [RUN_W-1:0] n;
    if (len == '0) begin
      n = RUN_W'(1);
    end else if (CNT_W'(len) > CNT_W'(MAX_RESULTS)) begin
      n = RUN_W'(MAX_RESULTS);
    end else begin
      n = RUN_W'(len);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

### rtl/tkg_if.sv
`default_nettype none
interface tkg_in_if;
  logic               valid;
  logic               ready;
  tkg_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tkg_out_if;
  logic               valid;
  logic               ready;
  tkg_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tkg_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [tkg_pkg::BYTE_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/tkg_ctrl.sv
`default_nettype none
module tkg_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire tkg_pkg::dp_status_t status,
  output tkg_pkg::dp_cmd_t         cmd
);

  tkg_pkg::ctrl_state_t state_r, state_nxt;
  logic run_is2_r, run_is2_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tkg_pkg::ST_IDLE;
      run_is2_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      run_is2_r <= run_is2_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    run_is2_nxt = run_is2_r;
    cmd         = '0;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    unique case (state_r)
      tkg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_byte = 1'b1;
          if (status.line_close) begin
            state_nxt = tkg_pkg::ST_CLOSE;
          end
        end
      end
      tkg_pkg::ST_CLOSE: begin
        if (status.first) begin
          cmd.take_line = 1'b1;
          state_nxt     = tkg_pkg::ST_FINISH;
        end else if (!status.len_eq) begin
          state_nxt = tkg_pkg::ST_RUN1;
        end else if (status.llen_zero) begin
          state_nxt = tkg_pkg::ST_FINISH;
        end else begin
          cmd.clr_idx = 1'b1;
          state_nxt   = tkg_pkg::ST_CMP_RD;
        end
      end
      tkg_pkg::ST_CMP_RD: begin
        state_nxt = tkg_pkg::ST_CMP_CHK;
      end
      tkg_pkg::ST_CMP_CHK: begin
        if (status.byte_ne) begin
          state_nxt = tkg_pkg::ST_RUN1;
        end else if (status.idx_last) begin
          state_nxt = tkg_pkg::ST_FINISH;
        end else begin
          cmd.inc_idx = 1'b1;
          state_nxt   = tkg_pkg::ST_CMP_RD;
        end
      end
      tkg_pkg::ST_RUN1: begin
        cmd.load_run1 = 1'b1;
        cmd.take_line = 1'b1;
        run_is2_nxt   = 1'b0;
        state_nxt     = tkg_pkg::ST_EMIT_RD;
      end
      tkg_pkg::ST_RUN2: begin
        cmd.load_run2 = 1'b1;
        run_is2_nxt   = 1'b1;
        state_nxt     = tkg_pkg::ST_EMIT_RD;
      end
      tkg_pkg::ST_EMIT_RD: begin
        state_nxt = tkg_pkg::ST_EMIT_LD;
      end
      tkg_pkg::ST_EMIT_LD: begin
        cmd.out_load = 1'b1;
        state_nxt    = tkg_pkg::ST_EMIT_WAIT;
      end
      tkg_pkg::ST_EMIT_WAIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.inc_idx = 1'b1;
          if (status.run_last) begin
            state_nxt = run_is2_r ? tkg_pkg::ST_RESTART : tkg_pkg::ST_FINISH;
          end else begin
            state_nxt = tkg_pkg::ST_EMIT_RD;
          end
        end
      end
      tkg_pkg::ST_FINISH: begin
        if (status.eos) begin
          state_nxt = tkg_pkg::ST_RUN2;
        end else begin
          cmd.line_reset = 1'b1;
          state_nxt      = tkg_pkg::ST_IDLE;
        end
      end
      tkg_pkg::ST_RESTART: begin
        cmd.restart = 1'b1;
        state_nxt   = tkg_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = tkg_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/tkg_dpath.sv
`default_nettype none
module tkg_dpath (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire tkg_pkg::dp_cmd_t                 cmd,
  output tkg_pkg::dp_status_t                   status,
  input  wire tkg_pkg::in_item_t                in_item,
  input  wire logic                             cfg_we,
  input  wire logic [tkg_pkg::BYTE_W-1:0]       cfg_wdata,
  output tkg_pkg::out_item_t                    out_item
);

  localparam int KLEN_W = tkg_pkg::KLEN_W;
  localparam int KIDX_W = tkg_pkg::KIDX_W;
  localparam int RUN_W  = tkg_pkg::RUN_W;
  localparam int CNT_W  = tkg_pkg::CNT_W;
  localparam int OFF_W  = tkg_pkg::OFFSET_BITS;
  localparam int BW     = tkg_pkg::BYTE_W;

  logic [BW-1:0] key_mem0_r [tkg_pkg::KEY_MAX];
  logic [BW-1:0] key_mem1_r [tkg_pkg::KEY_MAX];
  logic [BW-1:0] rd0_r, rd1_r;

  logic [BW-1:0]     key_field_r;
  logic              gsel_r;
  logic [KLEN_W-1:0] glen_r, llen_r;
  logic              gover_r, lover_r;
  logic [BW-1:0]     col_r;
  logic              first_r;
  logic              eos_r;
  logic [OFF_W-1:0]  offset_r, gbegin_r, lbegin_r;
  logic [CNT_W-1:0]  idx_r;
  logic [RUN_W-1:0]  produced_r;

  logic [OFF_W-1:0]  run_start_r, run_len_r;
  logic [KLEN_W-1:0] run_klen_r;
  logic              run_kover_r;
  logic              run_bank_r;
  logic [RUN_W-1:0]  run_cnt_r;

  tkg_pkg::out_item_t out_r;

  logic [BW-1:0]     b;
  logic              is_tab, is_nl, in_key, key_room, key_we;
  logic [KIDX_W-1:0] waddr, raddr;
  logic [RUN_W-1:0]  n1, n1_cut, n2, room;
  logic              run1_cut;
  logic [BW-1:0]     g_rd, l_rd, run_rd;

  assign b        = in_item.data_byte;
  assign is_tab   = (b == tkg_pkg::TAB_CHAR);
  assign is_nl    = (b == tkg_pkg::NL_CHAR);
  assign in_key   = !is_tab && !is_nl && (col_r == key_field_r);
  assign key_room = (llen_r < KLEN_W'(tkg_pkg::KEY_MAX));
  assign key_we   = cmd.take_byte && in_key && key_room;
  assign waddr    = KIDX_W'(llen_r);
  assign raddr    = KIDX_W'(idx_r);

  // line key lives in the bank that is not the group bank
  always_ff @(posedge clk) begin
    if (key_we && gsel_r) begin
      key_mem0_r[waddr] <= b;
    end
    rd0_r <= key_mem0_r[raddr];
  end

  always_ff @(posedge clk) begin
    if (key_we && !gsel_r) begin
      key_mem1_r[waddr] <= b;
    end
    rd1_r <= key_mem1_r[raddr];
  end

  assign g_rd   = gsel_r ? rd1_r : rd0_r;
  assign l_rd   = gsel_r ? rd0_r : rd1_r;
  assign run_rd = run_bank_r ? rd1_r : rd0_r;

  assign n1       = tkg_pkg::run_size(glen_r);
  assign run1_cut = eos_r && (n1 == RUN_W'(tkg_pkg::MAX_RESULTS));
  assign n1_cut   = run1_cut ? RUN_W'(tkg_pkg::MAX_RESULTS - 1) : n1;
  assign room     = RUN_W'(tkg_pkg::MAX_RESULTS) - produced_r;
  assign n2       = (tkg_pkg::run_size(glen_r) > room) ? room : tkg_pkg::run_size(glen_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_field_r <= BW'(1);
    end else if (cfg_we) begin
      key_field_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gsel_r     <= 1'b0;
      glen_r     <= '0;
      gover_r    <= 1'b0;
      llen_r     <= '0;
      lover_r    <= 1'b0;
      col_r      <= BW'(1);
      first_r    <= 1'b1;
      eos_r      <= 1'b0;
      offset_r   <= '0;
      gbegin_r   <= '0;
      lbegin_r   <= '0;
      idx_r      <= '0;
      produced_r <= '0;
    end else begin
      if (cmd.take_byte) begin
        if (is_tab) begin
          if (col_r != tkg_pkg::COL_MAX) begin
            col_r <= col_r + BW'(1);
          end
        end else if (in_key) begin
          if (key_room) begin
            llen_r <= llen_r + KLEN_W'(1);
          end else begin
            lover_r <= 1'b1;
          end
        end
        offset_r   <= offset_r + OFF_W'(1);
        eos_r      <= in_item.end_of_stream;
        produced_r <= '0;
      end
      if (cmd.take_line) begin
        gsel_r   <= !gsel_r;
        glen_r   <= llen_r;
        gover_r  <= lover_r;
        gbegin_r <= lbegin_r;
        first_r  <= 1'b0;
      end
      if (cmd.load_run1) begin
        produced_r <= n1_cut;
      end
      if (cmd.clr_idx || cmd.load_run1 || cmd.load_run2) begin
        idx_r <= '0;
      end else if (cmd.inc_idx) begin
        idx_r <= idx_r + CNT_W'(1);
      end
      if (cmd.line_reset) begin
        lbegin_r <= offset_r;
        llen_r   <= '0;
        lover_r  <= 1'b0;
        col_r    <= BW'(1);
      end
      if (cmd.restart) begin
        llen_r   <= '0;
        lover_r  <= 1'b0;
        glen_r   <= '0;
        gover_r  <= 1'b0;
        col_r    <= BW'(1);
        first_r  <= 1'b1;
        offset_r <= '0;
        gbegin_r <= '0;
        lbegin_r <= '0;
      end
    end
  end

  // a first run cut at end of stream carries the new group's key fields
  always_ff @(posedge clk) begin
    if (cmd.load_run1) begin
      run_start_r <= gbegin_r;
      run_len_r   <= lbegin_r - gbegin_r;
      run_klen_r  <= run1_cut ? llen_r : glen_r;
      run_kover_r <= run1_cut ? lover_r : gover_r;
      run_bank_r  <= run1_cut ? !gsel_r : gsel_r;
      run_cnt_r   <= n1_cut;
    end else if (cmd.load_run2) begin
      run_start_r <= gbegin_r;
      run_len_r   <= offset_r - gbegin_r;
      run_klen_r  <= glen_r;
      run_kover_r <= gover_r;
      run_bank_r  <= gsel_r;
      run_cnt_r   <= n2;
    end
  end

  // positions past the stored key read as zero
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.group_start   <= tkg_pkg::POS_W'(run_start_r);
      out_r.group_length  <= tkg_pkg::POS_W'(run_len_r);
      out_r.key_length    <= tkg_pkg::KEY_LEN_OUT_W'(run_klen_r);
      out_r.key_byte      <= (idx_r >= CNT_W'(run_klen_r)) ? '0 : run_rd;
      out_r.key_truncated <= run_kover_r;
      out_r.last          <= status.run_last;
    end
  end

  assign out_item = out_r;

  assign status.line_close = is_nl || in_item.end_of_stream;
  assign status.first      = first_r;
  assign status.eos        = eos_r;
  assign status.len_eq     = (llen_r == glen_r) && (lover_r == gover_r);
  assign status.llen_zero  = (llen_r == '0);
  assign status.byte_ne    = (l_rd != g_rd);
  assign status.idx_last   = (idx_r + CNT_W'(1) == CNT_W'(llen_r));
  assign status.run_last   = (idx_r + CNT_W'(1) == CNT_W'(run_cnt_r));

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (llen_r <= KLEN_W'(tkg_pkg::KEY_MAX)) && (glen_r <= KLEN_W'(tkg_pkg::KEY_MAX)))
    else $error("key length beyond KEY_MAX");

  a_take_line: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take_line && !cmd.restart |=> (glen_r == $past(llen_r)) && (gover_r == $past(lover_r))
                                      && (gsel_r != $past(gsel_r)))
    else $error("group key not taken from line key");

  a_run_index: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (run_cnt_r != '0) && (idx_r < CNT_W'(run_cnt_r)))
    else $error("run index outside run");

  a_run_fits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_run2 |-> (n2 != '0) && (CNT_W'(produced_r) + CNT_W'(n2) <= CNT_W'(tkg_pkg::MAX_RESULTS)))
    else $error("two runs exceed result limit");

endmodule
`default_nettype wire

### rtl/tsv_key_group_segmenter.sv
// Channel | Dir | Payload                                      | Transfer
// in_ch   | in  | data_byte, end_of_stream                     | valid && ready
// out_ch  | out | group_start, group_length, key_length,       | valid && ready
//         |     | key_byte, key_truncated, last                |
// cfg_ch  | in  | key_field                                    | valid && ready
//
// At a line end the line key is compared with the group key when the lengths match, byte
// by byte through the key bank read ports. Each result waits out any out_ch stall; no input
// byte is taken while a line end is handled or results are emitted.
// cfg_ch is always ready. Reset is synchronous: key_field returns to 1, no clearing pass.
`default_nettype none
module tsv_key_group_segmenter (
  input  wire logic clk,
  input  wire logic rst_n,
  tkg_in_if.sink    in_ch,
  tkg_out_if.source out_ch,
  tkg_cfg_if.sink   cfg_ch
);

  tkg_pkg::dp_cmd_t    cmd;
  tkg_pkg::dp_status_t status;

  assign cfg_ch.ready = 1'b1;

  tkg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  tkg_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_item   (in_ch.data),
    .cfg_we    (cfg_ch.valid),
    .cfg_wdata (cfg_ch.data),
    .out_item  (out_ch.data)
  );

endmodule
`default_nettype wire
